/* sv/v29_symbol_slicer_top_defines.svh */
// Assertion macros for the V.29 symbol slicer.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef V29_SYMBOL_SLICER_TOP_DEFINES_SVH
`define V29_SYMBOL_SLICER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define V29SS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("v29 slicer assertion failed");

// Next-cycle implication, disabled while in reset.
`define V29SS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("v29 slicer assertion failed");

`endif

/* sv/v29ss_pkg.sv */
// Package for the V.29 symbol slicer: constellation constants, stage types
// and the point tables. No dependencies.
`default_nettype none

package v29ss_pkg;

    localparam logic [15:0] Unit1 = 16'h1555;
    localparam logic [15:0] Unit2 = 16'h2AAA;
    localparam logic [15:0] Unit3 = 16'h4000;
    localparam logic [15:0] Unit4 = 16'h5555;
    localparam logic [15:0] Unit5 = 16'h6AAA;

    localparam int DistW = 34;
    localparam int TwoU1 = 2 * 16'h1555;
    localparam int TwoU3 = 2 * 16'h4000;
    localparam int TwoU3mU1 = 2 * (16'h4000 - 16'h1555);
    localparam int TwoU5mU3 = 2 * (16'h6AAA - 16'h4000);
    localparam int KInner = 16'h4000 * 16'h4000 - 2 * 16'h1555 * 16'h1555;
    localparam int KOuter = 16'h6AAA * 16'h6AAA - 2 * 16'h4000 * 16'h4000;
    localparam logic [15:0] InnerSum = 16'h2AAA + 16'h2AAA;
    localparam logic [14:0] HalfU3 = 15'h2000;

    typedef struct packed {
        logic [14:0] mag_hi;
        logic [14:0] mag_lo;
        logic        swapped;
        logic        re_neg;
        logic        im_neg;
    } fold_t;

    typedef struct packed {
        logic [3:0]         point_index;
        logic signed [15:0] ideal_re;
        logic signed [15:0] ideal_im;
        logic [15:0]        phase_angle;
    } point_t;

    function automatic logic [3:0] octant_map(input logic [2:0] idx);
        logic [3:0] p;
        case (idx)
            3'd0:    p = 4'd0;
            3'd1:    p = 4'd1;
            3'd2:    p = 4'd2;
            3'd3:    p = 4'd3;
            3'd4:    p = 4'd4;
            3'd5:    p = 4'd5;
            3'd6:    p = 4'd2;
            default: p = 4'd3;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] re_neg_map(input logic [3:0] idx);
        logic [3:0] p;
        case (idx)
            4'd1:    p = 4'd9;
            4'd2:    p = 4'd6;
            4'd3:    p = 4'd7;
            4'd4:    p = 4'd4;
            4'd5:    p = 4'd5;
            default: p = 4'd8;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] im_neg_map(input logic [3:0] idx);
        logic [3:0] p;
        case (idx)
            4'd1:    p = 4'd1;
            4'd2:    p = 4'd14;
            4'd3:    p = 4'd15;
            4'd4:    p = 4'd12;
            4'd5:    p = 4'd13;
            4'd6:    p = 4'd10;
            4'd7:    p = 4'd11;
            4'd8:    p = 4'd8;
            4'd9:    p = 4'd9;
            default: p = 4'd0;
        endcase
        return p;
    endfunction

    function automatic point_t point_lookup(input logic [3:0] idx);
        point_t r;
        r.point_index = idx;
        case (idx)
            4'd0:    begin r.ideal_re = 16'sh4000; r.ideal_im = 16'sh0000; end
            4'd1:    begin r.ideal_re = 16'sh6AAA; r.ideal_im = 16'sh0000; end
            4'd2:    begin r.ideal_re = 16'sh1555; r.ideal_im = 16'sh1555; end
            4'd3:    begin r.ideal_re = 16'sh4000; r.ideal_im = 16'sh4000; end
            4'd4:    begin r.ideal_re = 16'sh0000; r.ideal_im = 16'sh4000; end
            4'd5:    begin r.ideal_re = 16'sh0000; r.ideal_im = 16'sh6AAA; end
            4'd6:    begin r.ideal_re = 16'shEAAB; r.ideal_im = 16'sh1555; end
            4'd7:    begin r.ideal_re = 16'shC000; r.ideal_im = 16'sh4000; end
            4'd8:    begin r.ideal_re = 16'shC000; r.ideal_im = 16'sh0000; end
            4'd9:    begin r.ideal_re = 16'sh9556; r.ideal_im = 16'sh0000; end
            4'd10:   begin r.ideal_re = 16'shEAAB; r.ideal_im = 16'shEAAB; end
            4'd11:   begin r.ideal_re = 16'shC000; r.ideal_im = 16'shC000; end
            4'd12:   begin r.ideal_re = 16'sh0000; r.ideal_im = 16'shC000; end
            4'd13:   begin r.ideal_re = 16'sh0000; r.ideal_im = 16'sh9556; end
            4'd14:   begin r.ideal_re = 16'sh1555; r.ideal_im = 16'shEAAB; end
            default: begin r.ideal_re = 16'sh4000; r.ideal_im = 16'shC000; end
        endcase
        r.phase_angle = {idx[3:1], 13'd0};
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/v29ss_sample_if.sv */
// Channel carrying one demodulated complex sample per transaction.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface v29ss_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;

    modport source (output valid, output sample_re, output sample_im, input ready);
    modport sink (input valid, input sample_re, input sample_im, output ready);
endinterface

`default_nettype wire

/* sv/v29ss_point_if.sv */
// Channel carrying one decided constellation point per transaction.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface v29ss_point_if;
    logic               valid;
    logic               ready;
    logic [3:0]         point_index;
    logic signed [15:0] ideal_re;
    logic signed [15:0] ideal_im;
    logic [15:0]        phase_angle;

    modport source (output valid, output point_index, output ideal_re, output ideal_im,
                    output phase_angle, input ready);
    modport sink (input valid, input point_index, input ideal_re, input ideal_im,
                  input phase_angle, output ready);
endinterface

`default_nettype wire

/* sv/v29ss_fold.sv */
// Folds a complex sample into the first octant: saturating magnitudes,
// ordered so the larger comes first, plus the sign and swap flags. Uses v29ss_pkg.
`default_nettype none

module v29ss_fold
    import v29ss_pkg::*;
(
    input  wire logic signed [15:0] sample_re,
    input  wire logic signed [15:0] sample_im,
    output fold_t                   fold
);

    logic [14:0] mag_re;
    logic [14:0] mag_im;
    logic        swap;

    function automatic logic [14:0] sat_abs(input logic signed [15:0] v);
        logic [15:0] neg;
        neg = 16'(-v);
        if (!v[15])
        begin
            return v[14:0];
        end
        else if (neg[15])
        begin
            return 15'h7FFF;
        end
        else
        begin
            return neg[14:0];
        end
    endfunction

    always_comb
    begin
        mag_re = sat_abs(sample_re);
        mag_im = sat_abs(sample_im);
        swap = mag_re < mag_im;
        fold.mag_hi = swap ? mag_im : mag_re;
        fold.mag_lo = swap ? mag_re : mag_im;
        fold.swapped = swap;
        fold.re_neg = sample_re[15];
        fold.im_neg = sample_im[15];
    end

endmodule

`default_nettype wire

/* sv/v29ss_decide.sv */
// Picks the nearest first-octant point of a folded sample and mirrors it into
// the true quadrant. Distance comparisons are reduced to linear tests. Uses v29ss_pkg.
`default_nettype none

module v29ss_decide
    import v29ss_pkg::*;
(
    input  wire fold_t fold,
    output point_t     point
);

    logic [DistW-1:0] inner_lhs;
    logic [DistW-1:0] inner_rhs;
    logic [DistW-1:0] outer_lhs;
    logic [DistW-1:0] outer_rhs;
    logic [15:0]      mag_sum;
    logic [1:0]       pick;
    logic [3:0]       p_oct;
    logic [3:0]       p_re;
    logic [3:0]       p_im;

    always_comb
    begin
        // Both sides of each comparison are the squared distances with the
        // common quadratic terms cancelled; every term is non-negative.
        inner_lhs = DistW'(fold.mag_lo) * DistW'(TwoU1) + DistW'(KInner);
        inner_rhs = DistW'(fold.mag_hi) * DistW'(TwoU3mU1);
        outer_lhs = DistW'(fold.mag_lo) * DistW'(TwoU3) + DistW'(KOuter);
        outer_rhs = DistW'(fold.mag_hi) * DistW'(TwoU5mU3);
        mag_sum = 16'(fold.mag_hi) + 16'(fold.mag_lo);

        if (16'(fold.mag_hi) >= Unit4)
        begin
            pick = (outer_lhs > outer_rhs) ? 2'd3 : 2'd1;
        end
        else if (mag_sum < InnerSum)
        begin
            pick = (inner_lhs > inner_rhs) ? 2'd2 : 2'd0;
        end
        else
        begin
            pick = (fold.mag_lo > HalfU3) ? 2'd3 : 2'd0;
        end

        p_oct = octant_map({fold.swapped, pick});
        p_re = fold.re_neg ? re_neg_map(p_oct) : p_oct;
        p_im = fold.im_neg ? im_neg_map(p_re) : p_re;
        point = point_lookup(p_im);
    end

endmodule

`default_nettype wire

/* sv/v29_symbol_slicer_top.sv */
// V.29 9600 bit/s symbol slicer. Each sample transaction is folded into the
// first octant and registered, then decided and registered as a point
// transaction. One sample is accepted every cycle while the output side keeps
// taking results; the two register stages stall together only when the output
// is held back.
// Depends on v29ss_pkg, both channel interfaces, v29ss_fold, v29ss_decide and
// v29_symbol_slicer_top_defines.svh.
`default_nettype none
`include "v29_symbol_slicer_top_defines.svh"

module v29_symbol_slicer_top
    import v29ss_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    v29ss_sample_if.sink  sample,
    v29ss_point_if.source point
);

    fold_t  fold_now;
    fold_t  fold_reg;
    point_t point_now;
    point_t point_reg;
    logic   s1_valid_reg;
    logic   s1_valid_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   s1_load;
    logic   out_load;

    v29ss_fold u_fold (
        .sample_re (sample.sample_re),
        .sample_im (sample.sample_im),
        .fold      (fold_now)
    );

    v29ss_decide u_decide (
        .fold  (fold_reg),
        .point (point_now)
    );

    always_comb
    begin
        out_load = s1_valid_reg && (!out_valid_reg || point.ready);
        sample.ready = !s1_valid_reg || out_load;
        s1_load = sample.valid && sample.ready;
        s1_valid_next = s1_load || (s1_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && !point.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            fold_reg <= fold_now;
        end
        if (out_load)
        begin
            point_reg <= point_now;
        end
    end

    assign point.valid = out_valid_reg;
    assign point.point_index = point_reg.point_index;
    assign point.ideal_re = point_reg.ideal_re;
    assign point.ideal_im = point_reg.ideal_im;
    assign point.phase_angle = point_reg.phase_angle;

    `V29SS_ASSERT_NEXT(a_sample_lands, s1_load, s1_valid_reg)
    `V29SS_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !out_load, s1_valid_reg && $stable(fold_reg))
    `V29SS_ASSERT_NOW(a_axis_angle, point.valid,
        (point.ideal_re == 16'sd0) == (point.phase_angle == 16'h4000 || point.phase_angle == 16'hC000))

endmodule

`default_nettype wire
